// ===== design/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GNF_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gnf assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define GNF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gnf assertion failed");

`endif

// ===== design/gnf_pkg.sv =====
// Package with the constants, register codes and hash table of the fractal noise block.
package gnf_pkg;

    localparam int GNF_MAX_OCTAVES     = 8;
    localparam int GNF_COORD_FRAC_BITS = 16;

    // Quotient bits of the final normalization; the quotient never exceeds 3 * 2^12.
    localparam int Q_BITS   = 15;
    localparam int AMP_W    = 17;
    localparam int OUT_W    = 16;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 2;

    localparam logic [AMP_W-1:0] ONE_Q16 = 17'd65536;

    localparam logic [CFG_IDX_W-1:0] CFG_OCTAVE_COUNT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_FREQUENCY = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PERSISTENCE    = 2'd2;

    localparam logic [3:0]  RST_OCTAVE_COUNT   = 4'd4;
    localparam logic [15:0] RST_BASE_FREQUENCY = 16'd256;
    localparam logic [15:0] RST_PERSISTENCE    = 16'd32768;

    localparam int HASH_LEN = 198;

    localparam logic [7:0] HASH_P [0:HASH_LEN-1] = '{
        8'd151, 8'd160, 8'd137, 8'd91,  8'd90,  8'd15,  8'd131, 8'd13,  8'd201, 8'd95,
        8'd96,  8'd53,  8'd194, 8'd233, 8'd7,   8'd225, 8'd140, 8'd36,  8'd103, 8'd30,
        8'd69,  8'd142, 8'd8,   8'd99,  8'd37,  8'd240, 8'd21,  8'd10,  8'd23,  8'd190,
        8'd6,   8'd148, 8'd247, 8'd120, 8'd234, 8'd75,  8'd0,   8'd26,  8'd197, 8'd62,
        8'd94,  8'd252, 8'd219, 8'd203, 8'd117, 8'd35,  8'd11,  8'd32,  8'd57,  8'd177,
        8'd33,  8'd88,  8'd237, 8'd149, 8'd56,  8'd87,  8'd174, 8'd20,  8'd125, 8'd136,
        8'd171, 8'd168, 8'd68,  8'd175, 8'd74,  8'd165, 8'd71,  8'd134, 8'd139, 8'd48,
        8'd27,  8'd166, 8'd77,  8'd146, 8'd158, 8'd231, 8'd83,  8'd111, 8'd229, 8'd122,
        8'd60,  8'd211, 8'd133, 8'd230, 8'd220, 8'd105, 8'd92,  8'd41,  8'd55,  8'd46,
        8'd245, 8'd40,  8'd244, 8'd102, 8'd143, 8'd54,  8'd65,  8'd25,  8'd63,  8'd161,
        8'd1,   8'd216, 8'd80,  8'd73,  8'd209, 8'd76,  8'd132, 8'd187, 8'd208, 8'd89,
        8'd18,  8'd169, 8'd200, 8'd196, 8'd135, 8'd130, 8'd116, 8'd188, 8'd159, 8'd86,
        8'd164, 8'd100, 8'd109, 8'd198, 8'd173, 8'd186, 8'd3,   8'd64,  8'd52,  8'd217,
        8'd226, 8'd250, 8'd124, 8'd123, 8'd5,   8'd202, 8'd38,  8'd147, 8'd118, 8'd126,
        8'd255, 8'd82,  8'd85,  8'd212, 8'd207, 8'd206, 8'd59,  8'd227, 8'd47,  8'd16,
        8'd58,  8'd17,  8'd182, 8'd189, 8'd28,  8'd42,  8'd223, 8'd183, 8'd170, 8'd213,
        8'd119, 8'd248, 8'd152, 8'd2,   8'd44,  8'd145, 8'd31,  8'd179, 8'd228, 8'd167,
        8'd218, 8'd204, 8'd124, 8'd34,  8'd254, 8'd19,  8'd84,  8'd236, 8'd98,  8'd138,
        8'd205, 8'd93,  8'd222, 8'd114, 8'd67,  8'd29,  8'd24,  8'd72,  8'd243, 8'd141,
        8'd128, 8'd195, 8'd78,  8'd66,  8'd215, 8'd61,  8'd156, 8'd180
    };

    // The 512-entry hash ROM holds the hash table twice and zeros after that.
    function automatic logic [7:0] hash_rom(input logic [8:0] idx);
        logic [8:0] j;
        logic [7:0] val;
        j = 9'd0;
        if (idx < 9'(HASH_LEN)) begin
            val = HASH_P[idx[7:0]];
        end else if (idx < 9'(2 * HASH_LEN)) begin
            j = idx - 9'(HASH_LEN);
            val = HASH_P[j[7:0]];
        end else begin
            val = 8'd0;
        end
        return val;
    endfunction

endpackage

// ===== design/gnf_cell.sv =====
// One octave cell: lattice hash, fade, gradients, lerps and weighted accumulation.
module gnf_cell #(
    parameter int MAX_OCTAVES     = gnf_pkg::GNF_MAX_OCTAVES,
    parameter int COORD_FRAC_BITS = gnf_pkg::GNF_COORD_FRAC_BITS,
    parameter int OCT_IDX         = 0
) (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  logic                                          i_en,
    input  logic                                          i_valid,
    input  logic [COORD_FRAC_BITS+15:0]                   i_px,
    input  logic [COORD_FRAC_BITS+15:0]                   i_py,
    input  logic signed [38+$clog2(MAX_OCTAVES)-1:0]      i_total,
    input  logic [gnf_pkg::AMP_W-1:0]                     i_amp,
    input  logic [gnf_pkg::AMP_W+$clog2(MAX_OCTAVES)-1:0] i_amp_sum,
    input  logic [$clog2(MAX_OCTAVES+1)-1:0]              i_oct_count,
    input  logic [15:0]                                   i_persist,
    output logic                                          o_valid,
    output logic [COORD_FRAC_BITS+15:0]                   o_px,
    output logic [COORD_FRAC_BITS+15:0]                   o_py,
    output logic signed [38+$clog2(MAX_OCTAVES)-1:0]      o_total,
    output logic [gnf_pkg::AMP_W-1:0]                     o_amp,
    output logic [gnf_pkg::AMP_W+$clog2(MAX_OCTAVES)-1:0] o_amp_sum
);
    import gnf_pkg::*;

    localparam int SF    = COORD_FRAC_BITS + 8;
    localparam int W     = SF + 8;
    localparam int TOT_W = 38 + $clog2(MAX_OCTAVES);
    localparam int SUM_W = AMP_W + $clog2(MAX_OCTAVES);
    localparam int CNT_W = $clog2(MAX_OCTAVES + 1);
    localparam int SB_D  = 7;

    typedef struct packed {
        logic [W-1:0]            px;
        logic [W-1:0]            py;
        logic signed [TOT_W-1:0] total;
        logic [AMP_W-1:0]        amp;
        logic [SUM_W-1:0]        amp_sum;
    } t_side;

    function automatic logic [15:0] mul_q16(input logic [15:0] a, input logic [15:0] b);
        logic [31:0] p;
        p = a * b;
        return p[31:16];
    endfunction

    function automatic logic signed [18:0] corner(input logic [7:0] h,
                                                  input logic signed [16:0] dx,
                                                  input logic signed [16:0] dy);
        logic signed [18:0] u;
        logic signed [18:0] v;
        logic signed [18:0] a;
        logic signed [18:0] b;
        u = h[2] ? 19'(dy) : 19'(dx);
        v = h[2] ? 19'(dx) : 19'(dy);
        a = h[0] ? -u : u;
        b = h[1] ? -(v <<< 1) : (v <<< 1);
        return a + b;
    endfunction

    function automatic logic [16:0] fade(input logic [15:0] t3, input logic [15:0] t4,
                                         input logic [15:0] t5);
        logic signed [22:0] r;
        logic [16:0] res;
        r = $signed({7'd0, t5}) * 23'sd6 - $signed({7'd0, t4}) * 23'sd15
            + $signed({7'd0, t3}) * 23'sd10;
        if (r < 0) begin
            res = 17'd0;
        end else if (r > 23'sd65536) begin
            res = 17'd65536;
        end else begin
            res = r[16:0];
        end
        return res;
    endfunction

    // a + floor(t * (b - a) / 2^16); the result always lies between a and b.
    function automatic logic signed [18:0] lerp(input logic [16:0] t,
                                                input logic signed [18:0] a,
                                                input logic signed [18:0] b);
        logic signed [19:0] d;
        logic signed [37:0] p;
        logic signed [19:0] s;
        d = 20'(b) - 20'(a);
        p = $signed({1'b0, t}) * d;
        s = 20'(a) + 20'(p >>> 16);
        return s[18:0];
    endfunction

    logic [7:0]  cx, cy;
    logic [15:0] fx, fy;
    logic        act;

    assign cx  = i_px[SF+7:SF];
    assign cy  = i_py[SF+7:SF];
    assign fx  = i_px[SF-1:SF-16];
    assign fy  = i_py[SF-1:SF-16];
    assign act = (CNT_W+1)'(OCT_IDX) < {1'b0, i_oct_count};

    logic [7:0]  r1_hx0, r1_hx1, r1_cy;
    logic [15:0] r1_fx, r1_fy, r1_tx2, r1_ty2;
    logic [7:0]  r2_h00, r2_h01, r2_h10, r2_h11;
    logic [15:0] r2_fx, r2_fy, r2_tx3, r2_ty3;
    logic signed [18:0] r3_g00, r3_g01, r3_g10, r3_g11;
    logic [15:0] r3_fx, r3_fy, r3_tx3, r3_ty3, r3_tx4, r3_ty4;
    logic signed [18:0] r4_g00, r4_g01, r4_g10, r4_g11;
    logic [15:0] r4_tx3, r4_ty3, r4_tx4, r4_ty4, r4_tx5, r4_ty5;
    logic signed [18:0] r5_g00, r5_g01, r5_g10, r5_g11;
    logic [16:0] r5_u, r5_v;
    logic signed [18:0] r6_l0, r6_l1;
    logic [16:0] r6_v;
    logic signed [18:0] r7_n;

    logic [8:0] ha, hb;
    assign ha = {1'b0, r1_hx0} + {1'b0, r1_cy};
    assign hb = {1'b0, r1_hx1} + {1'b0, r1_cy};

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_hx0 <= hash_rom({1'b0, cx});
            r1_hx1 <= hash_rom({1'b0, cx} + 9'd1);
            r1_cy  <= cy;
            r1_fx  <= fx;
            r1_fy  <= fy;
            r1_tx2 <= mul_q16(fx, fx);
            r1_ty2 <= mul_q16(fy, fy);

            r2_h00 <= hash_rom(ha);
            r2_h01 <= hash_rom(ha + 9'd1);
            r2_h10 <= hash_rom(hb);
            r2_h11 <= hash_rom(hb + 9'd1);
            r2_fx  <= r1_fx;
            r2_fy  <= r1_fy;
            r2_tx3 <= mul_q16(r1_tx2, r1_fx);
            r2_ty3 <= mul_q16(r1_ty2, r1_fy);

            // The offset fx - 1.0 in 17-bit two's complement is fx with a set sign bit.
            r3_g00 <= corner(r2_h00, $signed({1'b0, r2_fx}), $signed({1'b0, r2_fy}));
            r3_g10 <= corner(r2_h10, $signed({1'b1, r2_fx}), $signed({1'b0, r2_fy}));
            r3_g01 <= corner(r2_h01, $signed({1'b0, r2_fx}), $signed({1'b1, r2_fy}));
            r3_g11 <= corner(r2_h11, $signed({1'b1, r2_fx}), $signed({1'b1, r2_fy}));
            r3_fx  <= r2_fx;
            r3_fy  <= r2_fy;
            r3_tx3 <= r2_tx3;
            r3_ty3 <= r2_ty3;
            r3_tx4 <= mul_q16(r2_tx3, r2_fx);
            r3_ty4 <= mul_q16(r2_ty3, r2_fy);

            r4_g00 <= r3_g00;
            r4_g01 <= r3_g01;
            r4_g10 <= r3_g10;
            r4_g11 <= r3_g11;
            r4_tx3 <= r3_tx3;
            r4_ty3 <= r3_ty3;
            r4_tx4 <= r3_tx4;
            r4_ty4 <= r3_ty4;
            r4_tx5 <= mul_q16(r3_tx4, r3_fx);
            r4_ty5 <= mul_q16(r3_ty4, r3_fy);

            r5_g00 <= r4_g00;
            r5_g01 <= r4_g01;
            r5_g10 <= r4_g10;
            r5_g11 <= r4_g11;
            r5_u   <= fade(r4_tx3, r4_tx4, r4_tx5);
            r5_v   <= fade(r4_ty3, r4_ty4, r4_ty5);

            r6_l0  <= lerp(r5_u, r5_g00, r5_g10);
            r6_l1  <= lerp(r5_u, r5_g01, r5_g11);
            r6_v   <= r5_v;

            r7_n   <= lerp(r6_v, r6_l0, r6_l1);
        end
    end

    t_side        r_sb [0:SB_D-1];
    logic [SB_D-1:0] r_v;
    logic         r_o_v;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sb[0] <= '{px: i_px, py: i_py, total: i_total, amp: i_amp, amp_sum: i_amp_sum};
            for (int k = 1; k < SB_D; k++) begin
                r_sb[k] <= r_sb[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v   <= '0;
            r_o_v <= 1'b0;
        end else if (i_en) begin
            r_v   <= {r_v[SB_D-2:0], i_valid};
            r_o_v <= r_v[SB_D-1];
        end
    end

    // The active flag is taken at the cell's input; the user keeps the octave count static while busy (not enforced).
    logic signed [36:0] prod;
    logic [32:0]        amp_prod;
    logic               r_act [0:SB_D-1];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_act[0] <= act;
            for (int k = 1; k < SB_D; k++) begin
                r_act[k] <= r_act[k-1];
            end
        end
    end

    assign prod     = r7_n * $signed({1'b0, r_sb[SB_D-1].amp});
    assign amp_prod = r_sb[SB_D-1].amp * i_persist;

    logic [W-1:0]            r_o_px, r_o_py;
    logic signed [TOT_W-1:0] r_o_total;
    logic [AMP_W-1:0]        r_o_amp;
    logic [SUM_W-1:0]        r_o_amp_sum;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_o_px <= {r_sb[SB_D-1].px[W-2:0], 1'b0};
            r_o_py <= {r_sb[SB_D-1].py[W-2:0], 1'b0};
            if (r_act[SB_D-1]) begin
                r_o_total   <= $signed(r_sb[SB_D-1].total) + TOT_W'(prod);
                r_o_amp     <= amp_prod[32:16];
                r_o_amp_sum <= r_sb[SB_D-1].amp_sum + SUM_W'(r_sb[SB_D-1].amp);
            end else begin
                r_o_total   <= r_sb[SB_D-1].total;
                r_o_amp     <= r_sb[SB_D-1].amp;
                r_o_amp_sum <= r_sb[SB_D-1].amp_sum;
            end
        end
    end

    assign o_valid   = r_o_v;
    assign o_px      = r_o_px;
    assign o_py      = r_o_py;
    assign o_total   = r_o_total;
    assign o_amp     = r_o_amp;
    assign o_amp_sum = r_o_amp_sum;

endmodule

// ===== design/gnf_div_step.sv =====
// One restoring division step that settles a single quotient bit.
module gnf_div_step #(
    parameter int DIV_W = 56,
    parameter int K     = 0
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_valid,
    input  logic [DIV_W-1:0]           i_rem,
    input  logic [DIV_W-1:0]           i_den,
    input  logic [gnf_pkg::Q_BITS-1:0] i_quo,
    input  logic                       i_neg,
    output logic                       o_valid,
    output logic [DIV_W-1:0]           o_rem,
    output logic [DIV_W-1:0]           o_den,
    output logic [gnf_pkg::Q_BITS-1:0] o_quo,
    output logic                       o_neg
);
    import gnf_pkg::*;

    logic [DIV_W-1:0]  shifted;
    logic              fits;
    logic [Q_BITS-1:0] n_quo;

    assign shifted = i_den << K;
    assign fits    = i_rem >= shifted;

    always_comb begin
        n_quo    = i_quo;
        n_quo[K] = fits;
    end

    logic                r_v;
    logic [DIV_W-1:0]    r_rem, r_den;
    logic [Q_BITS-1:0]   r_quo;
    logic                r_neg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (i_en) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem <= fits ? i_rem - shifted : i_rem;
            r_den <= i_den;
            r_quo <= n_quo;
            r_neg <= i_neg;
        end
    end

    assign o_valid = r_v;
    assign o_rem   = r_rem;
    assign o_den   = r_den;
    assign o_quo   = r_quo;
    assign o_neg   = r_neg;

endmodule

// ===== design/gradient_noise_fbm_2d.sv =====
// Fractal 2D gradient noise: a chain of octave cells followed by a pipelined divider.
// One point is accepted every cycle while o_in_stall is low;
// each octave cell and each quotient bit is its own stage.
// A skid register behind the output register keeps one result while the output stalls.
// Reset is synchronous and active low; registers return to 4 octaves, 1.0, 0.5.
module gradient_noise_fbm_2d #(
    parameter int MAX_OCTAVES     = gnf_pkg::GNF_MAX_OCTAVES,
    parameter int COORD_FRAC_BITS = gnf_pkg::GNF_COORD_FRAC_BITS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic signed [COORD_FRAC_BITS+7:0]   i_x_coord,
    input  logic signed [COORD_FRAC_BITS+7:0]   i_y_coord,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic signed [gnf_pkg::OUT_W-1:0]    o_noise_value,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [gnf_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [gnf_pkg::CFG_W-1:0]           i_cfg_data
);
    import gnf_pkg::*;

    localparam int IN_W  = COORD_FRAC_BITS + 8;
    localparam int W     = COORD_FRAC_BITS + 16;
    localparam int TOT_W = 38 + $clog2(MAX_OCTAVES);
    localparam int SUM_W = AMP_W + $clog2(MAX_OCTAVES);
    localparam int CNT_W = $clog2(MAX_OCTAVES + 1);
    localparam int DIV_W = TOT_W + Q_BITS;

    // Configuration registers.
    logic [3:0]  r_oct_count;
    logic [15:0] r_base_freq;
    logic [15:0] r_persist;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oct_count <= RST_OCTAVE_COUNT;
            r_base_freq <= RST_BASE_FREQUENCY;
            r_persist   <= RST_PERSISTENCE;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_OCTAVE_COUNT:   r_oct_count <= i_cfg_data[3:0];
                CFG_BASE_FREQUENCY: r_base_freq <= i_cfg_data;
                CFG_PERSISTENCE:    r_persist   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Octave count limited to the range one to MAX_OCTAVES.
    logic [CNT_W+3:0] oc_ext;
    logic [CNT_W-1:0] n_eff;

    assign oc_ext = (CNT_W+4)'(r_oct_count);

    always_comb begin
        priority if (oc_ext == '0) begin
            n_eff = CNT_W'(1);
        end else if (oc_ext > (CNT_W+4)'(MAX_OCTAVES)) begin
            n_eff = CNT_W'(MAX_OCTAVES);
        end else begin
            n_eff = oc_ext[CNT_W-1:0];
        end
    end

    logic r_skid_v;
    logic en;

    assign en         = !r_skid_v;
    assign o_in_stall = r_skid_v;

    // Scale the point by the base frequency.
    logic signed [IN_W+16:0] mx, my;
    logic                    r_in_v;
    logic [W-1:0]            r_in_px, r_in_py;

    assign mx = i_x_coord * $signed({1'b0, r_base_freq});
    assign my = i_y_coord * $signed({1'b0, r_base_freq});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v <= 1'b0;
        end else if (en) begin
            r_in_v <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_in_px <= mx[W-1:0];
            r_in_py <= my[W-1:0];
        end
    end

    logic                    c_v     [0:MAX_OCTAVES];
    logic [W-1:0]            c_px    [0:MAX_OCTAVES];
    logic [W-1:0]            c_py    [0:MAX_OCTAVES];
    logic signed [TOT_W-1:0] c_total [0:MAX_OCTAVES];
    logic [AMP_W-1:0]        c_amp   [0:MAX_OCTAVES];
    logic [SUM_W-1:0]        c_sum   [0:MAX_OCTAVES];

    assign c_v[0]     = r_in_v;
    assign c_px[0]    = r_in_px;
    assign c_py[0]    = r_in_py;
    assign c_total[0] = '0;
    assign c_amp[0]   = ONE_Q16;
    assign c_sum[0]   = '0;

    for (genvar gi = 0; gi < MAX_OCTAVES; gi++) begin : g_cell
        gnf_cell #(
            .MAX_OCTAVES    (MAX_OCTAVES),
            .COORD_FRAC_BITS(COORD_FRAC_BITS),
            .OCT_IDX        (gi)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_en       (en),
            .i_valid    (c_v[gi]),
            .i_px       (c_px[gi]),
            .i_py       (c_py[gi]),
            .i_total    (c_total[gi]),
            .i_amp      (c_amp[gi]),
            .i_amp_sum  (c_sum[gi]),
            .i_oct_count(n_eff),
            .i_persist  (r_persist),
            .o_valid    (c_v[gi+1]),
            .o_px       (c_px[gi+1]),
            .o_py       (c_py[gi+1]),
            .o_total    (c_total[gi+1]),
            .o_amp      (c_amp[gi+1]),
            .o_amp_sum  (c_sum[gi+1])
        );
    end

    // Sign and magnitude for the divider; the divisor is the amplitude sum times 16.
    logic                    d_v   [0:Q_BITS];
    logic [DIV_W-1:0]        d_rem [0:Q_BITS];
    logic [DIV_W-1:0]        d_den [0:Q_BITS];
    logic [Q_BITS-1:0]       d_quo [0:Q_BITS];
    logic                    d_neg [0:Q_BITS];

    logic                    r_a_v, r_a_neg;
    logic [DIV_W-1:0]        r_a_rem, r_a_den;
    logic signed [TOT_W-1:0] tot_abs;

    assign tot_abs = c_total[MAX_OCTAVES][TOT_W-1] ? -c_total[MAX_OCTAVES]
                                                   : c_total[MAX_OCTAVES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
        end else if (en) begin
            r_a_v <= c_v[MAX_OCTAVES];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_neg <= c_total[MAX_OCTAVES][TOT_W-1];
            r_a_rem <= DIV_W'(unsigned'(tot_abs));
            r_a_den <= DIV_W'({c_sum[MAX_OCTAVES], 4'd0});
        end
    end

    assign d_v[0]   = r_a_v;
    assign d_rem[0] = r_a_rem;
    assign d_den[0] = r_a_den;
    assign d_quo[0] = '0;
    assign d_neg[0] = r_a_neg;

    for (genvar gj = 0; gj < Q_BITS; gj++) begin : g_div
        gnf_div_step #(
            .DIV_W(DIV_W),
            .K    (Q_BITS - 1 - gj)
        ) u_step (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (en),
            .i_valid(d_v[gj]),
            .i_rem  (d_rem[gj]),
            .i_den  (d_den[gj]),
            .i_quo  (d_quo[gj]),
            .i_neg  (d_neg[gj]),
            .o_valid(d_v[gj+1]),
            .o_rem  (d_rem[gj+1]),
            .o_den  (d_den[gj+1]),
            .o_quo  (d_quo[gj+1]),
            .o_neg  (d_neg[gj+1])
        );
    end

    // Negative sums round toward minus infinity, then the result saturates.
    logic [Q_BITS:0]        q_mag;
    logic signed [Q_BITS+1:0] q_val;
    logic signed [OUT_W-1:0] res;

    assign q_mag = {1'b0, d_quo[Q_BITS]}
                 + (Q_BITS+1)'(d_neg[Q_BITS] && (d_rem[Q_BITS] != '0));
    assign q_val = d_neg[Q_BITS] ? -$signed({1'b0, q_mag}) : $signed({1'b0, q_mag});

    always_comb begin
        priority if (q_val > (Q_BITS+2)'(32767)) begin
            res = 16'sh7fff;
        end else if (q_val < -(Q_BITS+2)'(32768)) begin
            res = 16'sh8000;
        end else begin
            res = q_val[OUT_W-1:0];
        end
    end

    // Output register with a skid register behind it.
    logic                    r_out_v, n_out_v;
    logic signed [OUT_W-1:0] r_out_val, n_out_val;
    logic                    n_skid_v;
    logic signed [OUT_W-1:0] r_skid_val, n_skid_val;
    logic                    arrive, take;

    assign arrive = d_v[Q_BITS] && en;
    assign take   = r_out_v && !i_out_stall;

    always_comb begin
        n_out_v    = r_out_v;
        n_out_val  = r_out_val;
        n_skid_v   = r_skid_v;
        n_skid_val = r_skid_val;
        priority if (arrive) begin
            if (!r_out_v || take) begin
                n_out_v   = 1'b1;
                n_out_val = res;
            end else begin
                n_skid_v   = 1'b1;
                n_skid_val = res;
            end
        end else if (take) begin
            if (r_skid_v) begin
                n_out_val = r_skid_val;
                n_skid_v  = 1'b0;
            end else begin
                n_out_v = 1'b0;
            end
        end else begin
            n_out_v = r_out_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else begin
            r_out_v  <= n_out_v;
            r_skid_v <= n_skid_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_val  <= n_out_val;
        r_skid_val <= n_skid_val;
    end

    assign o_out_valid   = r_out_v;
    assign o_noise_value = r_out_val;

endmodule

// ===== design/gnf_checker.sv =====
// Port-level checker for the fractal noise block, bound to its top level.
`include "assert_macros.svh"

module gnf_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              o_in_stall,
    input logic                              o_out_valid,
    input logic                              i_out_stall,
    input logic signed [gnf_pkg::OUT_W-1:0]  o_noise_value
);

    // A stalled result stays offered and unchanged.
    `GNF_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid)
    `GNF_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, o_out_valid && i_out_stall, $stable(o_noise_value))

    // The input side only stalls after a result was held back on the output side.
    `GNF_ASSERT_SAME(a_stall_cause, i_clk, i_rst_n, o_in_stall, $past(o_out_valid && i_out_stall))

    // While the output keeps stalling, the buffered result keeps the input stalled.
    `GNF_ASSERT_NEXT(a_stall_keep, i_clk, i_rst_n, o_out_valid && i_out_stall && o_in_stall, o_in_stall)

endmodule

bind gradient_noise_fbm_2d gnf_checker u_gnf_checker (.*);
